// File: rtl/ssa_pkg.sv
// Shared types, codes and sizes for the segment scatter-add engine.
// No dependencies; every other file refers to this package by scoped names.
package ssa_pkg;

	localparam int STORE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CFG_W       = 13;
	localparam int COL_W       = 12;
	localparam int TGT_W       = 2 * CFG_W + 1;
	localparam int MAX_WIDTH   = 4096;

	localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
	localparam logic [1:0] CMD_READ       = 2'd1;
	localparam logic [1:0] CMD_WRITE      = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_SKIPPED = 2'd1;
	localparam logic [1:0] ST_BEYOND  = 2'd2;

	localparam logic [1:0] REG_ROW_WIDTH      = 2'd0;
	localparam logic [1:0] REG_OUT_ROW_STRIDE = 2'd1;
	localparam logic [1:0] REG_NUM_SEGMENTS   = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] value;
		logic signed [31:0] segment_index;
		logic [11:0]        entry_address;
		logic               last_element;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_data;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic calc;
		logic addr;
		logic exec;
	} ctl_t;

	typedef struct packed {
		logic clear_last;
	} sts_t;

endpackage

// File: rtl/ssa_ctrl.sv
// Controller for the segment scatter-add engine: clearing pass, then one request at a time.
// Depends on ssa_pkg for the command and status structs.
module ssa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ssa_pkg::sts_t sts,
	output ssa_pkg::ctl_t ctl,
	output logic          busy,
	output logic          done
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CALC,
		S_ADDR,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (sts.clear_last)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start)
						state_q <= S_CALC;
				end
				S_CALC: state_q <= S_ADDR;
				S_ADDR: state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.clear   = (state_q == S_CLEAR);
		ctl.capture = (state_q == S_IDLE) && start;
		ctl.calc    = (state_q == S_CALC);
		ctl.addr    = (state_q == S_ADDR);
		ctl.exec    = (state_q == S_EXEC);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// File: rtl/ssa_datapath.sv
// Datapath: configuration registers, column counter, address calculation and accumulator store.
// Depends on ssa_pkg; driven by ssa_ctrl through ctl_t and reports through sts_t.
module ssa_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssa_pkg::ctl_t                 ctl,
	output ssa_pkg::sts_t                 sts,
	input  ssa_pkg::req_t                 req,
	input  logic                          cfg_valid,
	input  logic [1:0]                    cfg_index,
	input  logic [ssa_pkg::CFG_W-1:0]     cfg_data,
	output ssa_pkg::rsp_t                 rsp
);

	logic [ssa_pkg::CFG_W-1:0] row_width_q;
	logic [ssa_pkg::CFG_W-1:0] stride_q;
	logic [ssa_pkg::CFG_W-1:0] num_seg_q;
	logic [ssa_pkg::COL_W-1:0] col_cnt_q;
	logic [ssa_pkg::ADDR_W-1:0] clr_q;

	ssa_pkg::req_t               req_q;
	logic                        skip_s1;
	logic [2*ssa_pkg::CFG_W-1:0] prod_s1;
	logic [ssa_pkg::COL_W-1:0]   col_s1;
	logic [ssa_pkg::ADDR_W-1:0]  mem_addr_s2;
	logic [1:0]                  status_s2;
	logic [31:0]                 rdata_s2;
	ssa_pkg::rsp_t               rsp_q;

	logic [31:0] store_q [ssa_pkg::STORE_DEPTH];

	logic [ssa_pkg::CFG_W-1:0] eff_width;
	logic [ssa_pkg::CFG_W-1:0] col_inc;
	logic                      seg_skip;
	logic [ssa_pkg::TGT_W-1:0] target;
	logic [ssa_pkg::TGT_W-1:0] sel_addr;
	logic                      is_acc;
	logic                      wr_en;
	logic [ssa_pkg::ADDR_W-1:0] wr_addr;
	logic [31:0]               wr_data;

	always_comb begin
		if (row_width_q == '0)
			eff_width = ssa_pkg::CFG_W'(1);
		else if (row_width_q > ssa_pkg::CFG_W'(ssa_pkg::MAX_WIDTH))
			eff_width = ssa_pkg::CFG_W'(ssa_pkg::MAX_WIDTH);
		else
			eff_width = row_width_q;
		col_inc  = {1'b0, col_cnt_q} + ssa_pkg::CFG_W'(1);
		seg_skip = req_q.segment_index[31] ||
			($unsigned(req_q.segment_index) >= 32'(num_seg_q));
		is_acc   = (req_q.command == ssa_pkg::CMD_ACCUMULATE);
		target   = {1'b0, prod_s1} + ssa_pkg::TGT_W'(col_s1);
		sel_addr = is_acc ? target : ssa_pkg::TGT_W'(req_q.entry_address);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ssa_pkg::CFG_W'(1);
			stride_q    <= ssa_pkg::CFG_W'(1);
			num_seg_q   <= ssa_pkg::CFG_W'(1);
			col_cnt_q   <= '0;
			clr_q       <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ssa_pkg::REG_ROW_WIDTH:      row_width_q <= cfg_data;
					ssa_pkg::REG_OUT_ROW_STRIDE: stride_q    <= cfg_data;
					ssa_pkg::REG_NUM_SEGMENTS:   num_seg_q   <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.clear)
				clr_q <= clr_q + ssa_pkg::ADDR_W'(1);
			if (ctl.calc && is_acc) begin
				if (req_q.last_element || col_inc >= eff_width)
					col_cnt_q <= '0;
				else
					col_cnt_q <= col_inc[ssa_pkg::COL_W-1:0];
			end
		end
	end

	assign sts.clear_last = (clr_q == ssa_pkg::ADDR_W'(ssa_pkg::STORE_DEPTH - 1));

	always_ff @(posedge clk) begin
		if (ctl.capture)
			req_q <= req;
		if (ctl.calc) begin
			skip_s1 <= seg_skip;
			prod_s1 <= req_q.segment_index[ssa_pkg::CFG_W-1:0] * stride_q;
			col_s1  <= col_cnt_q;
		end
		if (ctl.addr) begin
			mem_addr_s2 <= sel_addr[ssa_pkg::ADDR_W-1:0];
			rdata_s2    <= store_q[sel_addr[ssa_pkg::ADDR_W-1:0]];
			if (req_q.command == ssa_pkg::CMD_ACCUMULATE ||
			    req_q.command == ssa_pkg::CMD_READ ||
			    req_q.command == ssa_pkg::CMD_WRITE) begin
				if (is_acc && skip_s1)
					status_s2 <= ssa_pkg::ST_SKIPPED;
				else if (sel_addr >= ssa_pkg::TGT_W'(ssa_pkg::STORE_DEPTH))
					status_s2 <= ssa_pkg::ST_BEYOND;
				else
					status_s2 <= ssa_pkg::ST_DONE;
			end else begin
				status_s2 <= ssa_pkg::ST_DONE;
			end
		end
		if (ctl.exec) begin
			rsp_q.status <= status_s2;
			if (req_q.command == ssa_pkg::CMD_READ && status_s2 == ssa_pkg::ST_DONE)
				rsp_q.read_data <= rdata_s2;
			else
				rsp_q.read_data <= '0;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = mem_addr_s2;
		wr_data = req_q.value;
		if (ctl.clear) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (ctl.exec && status_s2 == ssa_pkg::ST_DONE) begin
			if (req_q.command == ssa_pkg::CMD_ACCUMULATE) begin
				wr_en   = 1'b1;
				wr_data = rdata_s2 + req_q.value;
			end else if (req_q.command == ssa_pkg::CMD_WRITE) begin
				wr_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			store_q[wr_addr] <= wr_data;
	end

	assign rsp = rsp_q;

endmodule

// File: rtl/segment_scatter_add.sv
// Top level of the segment scatter-add engine: joins controller and datapath.
// Depends on ssa_pkg, ssa_ctrl and ssa_datapath.
//
//  channel   handshake              payload
//  request   start, busy            req    (ssa_pkg::req_t)
//  result    done (one-cycle pulse) result (ssa_pkg::rsp_t)
//  config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// done rises once the request has gone through multiply, address add and store read, and
// read-modify-write, with the result registered at the end of the last. busy drops in the
// cycle that shows done, so the next request can be taken there; one request at a time.
// After reset the store is cleared one entry a cycle, all STORE_DEPTH entries, with busy high.
// The receiver cannot stall: result is valid only while done is high.
module segment_scatter_add (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  ssa_pkg::req_t             req,
	output logic                      done,
	output ssa_pkg::rsp_t             result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [ssa_pkg::CFG_W-1:0] cfg_data
);

	ssa_pkg::ctl_t ctl;
	ssa_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ssa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	ssa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp       (result)
	);

endmodule
